// ===== design/tsx_pkg.sv =====
// shared constants and control types for the trie subarray xor counter
package tsx_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned THR_W          = 32;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned TOTAL_W        = 20;

  typedef struct packed {
    logic start;
    logic init;
  } walk_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_sts_t;

endpackage

// ===== design/tsx_if.sv =====
// valid/ready channel interfaces for the trie subarray xor counter
interface tsx_in_if;
  logic                         valid;
  logic                         ready;
  logic [tsx_pkg::VALUE_W-1:0]  value;
  logic                         first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

interface tsx_out_if;
  logic                         valid;
  logic                         ready;
  logic [tsx_pkg::COUNT_W-1:0]  count_here;
  logic [tsx_pkg::TOTAL_W-1:0]  running_total;
  logic                         overflow;

  modport source (output valid, output count_here, output running_total, output overflow,
                  input ready);
  modport sink   (input valid, input count_here, input running_total, input overflow,
                  output ready);
endinterface

// ===== design/tsx_node_mem.sv =====
// trie node memory, one write port and one registered read port
module tsx_node_mem #(
  parameter int unsigned DEPTH  = 32801,
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 54
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tsx_walker.sv =====
// trie walk sequencer: root setup, threshold query walk and insert walk
module tsx_walker #(
  parameter int unsigned VALUE_BITS = tsx_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_ITEMS  = tsx_pkg::MAX_ITEMS_DEF,
  localparam int unsigned NODE_CAP  = 1 + VALUE_BITS * (MAX_ITEMS + 1),
  localparam int unsigned LINK_W    = $clog2(NODE_CAP),
  localparam int unsigned NF_W      = $clog2(NODE_CAP + 1),
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 2),
  localparam int unsigned DATA_W    = 2 * LINK_W + 2 * CNT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsx_pkg::walk_ctl_t    ctl_i,
  input  logic [VALUE_BITS-1:0] key_i,
  input  logic [VALUE_BITS-1:0] thr_i,
  input  logic                  thr_over_i,
  output tsx_pkg::walk_sts_t    sts_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  mem_we_o,
  output logic [LINK_W-1:0]     mem_waddr_o,
  output logic [DATA_W-1:0]     mem_wdata_o,
  output logic [LINK_W-1:0]     mem_raddr_o,
  input  logic [DATA_W-1:0]     mem_rdata_i
);

  localparam int unsigned LVL_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(VALUE_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_QRD  = 3'd2;
  localparam logic [2:0] S_QEV  = 3'd3;
  localparam logic [2:0] S_IRD  = 3'd4;
  localparam logic [2:0] S_IEV  = 3'd5;
  localparam logic [2:0] S_IFR  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [LINK_W-1:0]     cur_q, cur_d;
  logic [NF_W-1:0]       nf_q, nf_d;
  logic [CNT_W-1:0]      acc_q, acc_d;
  logic [VALUE_BITS-1:0] key_q;

  logic [CNT_W-1:0]  cnt0, cnt1, cnt_x, cnt_b, cnt_inc, acc_add;
  logic [LINK_W-1:0] ch0, ch1, ch_go, ch_b, ch_new, nf_link;
  logic              bx, bk, bit_w, alloc;
  logic [DATA_W-1:0] fresh_word, upd_word;

  assign cnt0 = mem_rdata_i[CNT_W-1:0];
  assign cnt1 = mem_rdata_i[2*CNT_W-1:CNT_W];
  assign ch0  = mem_rdata_i[2*CNT_W +: LINK_W];
  assign ch1  = mem_rdata_i[2*CNT_W+LINK_W +: LINK_W];

  assign nf_link = nf_q[LINK_W-1:0];

  // query step
  assign bx      = key_q[lvl_q];
  assign bk      = thr_i[lvl_q];
  assign cnt_x   = bx ? cnt1 : cnt0;
  assign acc_add = acc_q + (bk ? cnt_x : '0);
  assign ch_go   = (bx ^ bk) ? ch1 : ch0;

  // insert step on a node read from memory
  assign cnt_b   = bx ? cnt1 : cnt0;
  assign ch_b    = bx ? ch1 : ch0;
  assign alloc   = (ch_b == '0);
  assign ch_new  = alloc ? nf_link : ch_b;
  assign cnt_inc = cnt_b + CNT_W'(1);
  assign upd_word = bx ? {ch_new, ch0, cnt_inc, cnt0} : {ch1, ch_new, cnt1, cnt_inc};

  // newly allocated node, written whole without a read
  assign bit_w = (state_q == S_INIT) ? 1'b0 : bx;
  assign fresh_word = bit_w ? {nf_link, LINK_W'(0), CNT_W'(1), CNT_W'(0)}
                            : {LINK_W'(0), nf_link, CNT_W'(0), CNT_W'(1)};

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    cur_d       = cur_q;
    nf_d        = nf_q;
    acc_d       = acc_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = fresh_word;
    mem_raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          lvl_d = LVL_TOP;
          cur_d = '0;
          if (ctl_i.init) begin
            nf_d    = NF_W'(1);
            state_d = S_INIT;
          end else begin
            state_d = S_QRD;
          end
        end
      end
      S_INIT: begin
        mem_we_o = 1'b1;
        cur_d    = nf_link;
        nf_d     = nf_q + NF_W'(1);
        if (lvl_q == '0) begin
          state_d = S_QRD;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      S_QRD: begin
        lvl_d   = LVL_TOP;
        acc_d   = '0;
        state_d = S_QEV;
      end
      S_QEV: begin
        if (thr_over_i) begin
          acc_d   = cnt0 + cnt1;
          state_d = S_IRD;
        end else begin
          acc_d = acc_add;
          if (ch_go == '0 || lvl_q == '0) begin
            state_d = S_IRD;
          end else begin
            mem_raddr_o = ch_go;
            lvl_d       = lvl_q - LVL_W'(1);
          end
        end
      end
      S_IRD: begin
        lvl_d   = LVL_TOP;
        cur_d   = '0;
        state_d = S_IEV;
      end
      S_IEV: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = upd_word;
        mem_raddr_o = ch_new;
        cur_d       = ch_new;
        if (alloc) begin
          nf_d = nf_q + NF_W'(1);
        end
        if (lvl_q == '0) begin
          state_d = S_DONE;
        end else begin
          lvl_d   = lvl_q - LVL_W'(1);
          state_d = alloc ? S_IFR : S_IEV;
        end
      end
      S_IFR: begin
        mem_we_o = 1'b1;
        cur_d    = nf_link;
        nf_d     = nf_q + NF_W'(1);
        if (lvl_q == '0) begin
          state_d = S_DONE;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      cur_q   <= '0;
      nf_q    <= NF_W'(1);
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      cur_q   <= cur_d;
      nf_q    <= nf_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && ctl_i.start) begin
      key_q <= key_i;
    end
  end

  assign sts_o.busy = (state_q != S_IDLE);
  assign sts_o.done = (state_q == S_DONE);
  assign count_o    = acc_q;

`ifndef SYNTH
  a_nf_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NF_W'(NODE_CAP))
    else $error("node allocation ran past capacity");

  a_no_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRD || state_q == S_QEV) |-> !mem_we_o)
    else $error("node write during query walk");

  a_insert_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IEV) |-> (mem_raddr_o != mem_waddr_o))
    else $error("insert walk reads the node it writes");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |=> !sts_o.done && !sts_o.busy)
    else $error("walk done held too long");
`endif

endmodule

// ===== design/trie_subarray_xor_below_count.sv =====
// top level of the trie subarray xor below threshold counter
//
// usage: array elements come in on in_i, one transfer per element, with first
// set on the first element of each array. each element gives one result
// transfer on out_o: the number of subarrays ending there whose xor is below
// the threshold, the running total for the array and an overflow flag for
// elements past MAX_ITEMS. the threshold register is written through
// cfg_we_i / cfg_wdata_i while no element is in flight: a rule on the user that
// the block itself does not enforce. timing: a normal element's result follows
// its query walk, which can end early, and its insert walk, and in_i.ready
// returns as the result turns valid; the query walk and then the insert walk
// go through the single node memory one level per cycle. an element with first
// set writes the root path of prefix 0 before both walks. an overflowed element
// skips both walks, and the next element can be taken once its result moves on
// to the output register. in_i.ready is high only between elements.
// reset: the threshold goes to 0 and the block behaves as if an array had
// just started; the root path is written with the first element taken.
// stall: the result sits in the output register until out_o.ready; the next
// element is accepted meanwhile, and its result waits behind it.
module trie_subarray_xor_below_count #(
  parameter int unsigned MAX_ITEMS  = tsx_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = tsx_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tsx_pkg::THR_W-1:0] cfg_wdata_i,
  tsx_in_if.sink                    in_i,
  tsx_out_if.source                 out_o
);

  localparam int unsigned NODE_CAP = 1 + VALUE_BITS * (MAX_ITEMS + 1);
  localparam int unsigned LINK_W   = $clog2(NODE_CAP);
  localparam int unsigned CNT_W    = $clog2(MAX_ITEMS + 2);
  localparam int unsigned DATA_W   = 2 * LINK_W + 2 * CNT_W;
  localparam int unsigned ITEM_W   = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_RES  = 2'd2;

  logic [1:0]                    tstate_q;
  logic                          init_pend_q;
  logic [tsx_pkg::THR_W-1:0]     thr_q;
  logic [VALUE_BITS-1:0]         prefix_q;
  logic [ITEM_W-1:0]             items_q;
  logic [tsx_pkg::TOTAL_W-1:0]   total_q;
  logic                          out_valid_q;

  logic [tsx_pkg::COUNT_W-1:0]   res_count_q, out_count_q;
  logic [tsx_pkg::TOTAL_W-1:0]   res_total_q, out_total_q;
  logic                          res_ovf_q, out_ovf_q;

  logic                          accept, init, ovf, out_free;
  logic [VALUE_BITS-1:0]         base_prefix, new_prefix, thr_key;
  logic [ITEM_W-1:0]             items_base;
  logic [tsx_pkg::TOTAL_W-1:0]   total_base, total_sum;
  logic                          thr_over;

  tsx_pkg::walk_ctl_t            walk_ctl;
  tsx_pkg::walk_sts_t            walk_sts;
  logic [CNT_W-1:0]              walk_count;

  logic                          mem_we;
  logic [LINK_W-1:0]             mem_waddr, mem_raddr;
  logic [DATA_W-1:0]             mem_wdata, mem_rdata;

  assign in_i.ready  = (tstate_q == T_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign init        = in_i.first || init_pend_q;
  assign base_prefix = init ? '0 : prefix_q;
  assign new_prefix  = base_prefix ^ VALUE_BITS'(in_i.value);
  assign items_base  = init ? '0 : items_q;
  assign total_base  = init ? '0 : total_q;
  assign ovf         = (items_base >= ITEM_W'(MAX_ITEMS));
  assign total_sum   = total_q + tsx_pkg::TOTAL_W'(walk_count);
  assign out_free    = !out_valid_q || out_o.ready;

  assign thr_key  = VALUE_BITS'(thr_q);
  assign thr_over = (VALUE_BITS < tsx_pkg::THR_W) && ((thr_q >> VALUE_BITS) != '0);

  assign walk_ctl.start = accept && !ovf;
  assign walk_ctl.init  = init;

  tsx_walker #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (walk_ctl),
    .key_i       (new_prefix),
    .thr_i       (thr_key),
    .thr_over_i  (thr_over),
    .sts_o       (walk_sts),
    .count_o     (walk_count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tsx_node_mem #(
    .DEPTH  (NODE_CAP),
    .ADDR_W (LINK_W),
    .DATA_W (DATA_W)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q    <= T_IDLE;
      init_pend_q <= 1'b1;
      thr_q       <= '0;
      prefix_q    <= '0;
      items_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_o.ready && (tstate_q != T_RES)) begin
        out_valid_q <= 1'b0;
      end
      case (tstate_q)
        T_IDLE: begin
          if (accept) begin
            init_pend_q <= 1'b0;
            if (ovf) begin
              tstate_q <= T_RES;
            end else begin
              prefix_q <= new_prefix;
              items_q  <= items_base + ITEM_W'(1);
              total_q  <= total_base;
              tstate_q <= T_RUN;
            end
          end
        end
        T_RUN: begin
          if (walk_sts.done) begin
            total_q  <= total_sum;
            tstate_q <= T_RES;
          end
        end
        T_RES: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            tstate_q    <= T_IDLE;
          end
        end
        default: begin
          tstate_q <= T_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tstate_q == T_IDLE && accept && ovf) begin
      res_count_q <= '0;
      res_total_q <= total_base;
      res_ovf_q   <= 1'b1;
    end
    if (tstate_q == T_RUN && walk_sts.done) begin
      res_count_q <= tsx_pkg::COUNT_W'(walk_count);
      res_total_q <= total_sum;
      res_ovf_q   <= 1'b0;
    end
    if (tstate_q == T_RES && out_free) begin
      out_count_q <= res_count_q;
      out_total_q <= res_total_q;
      out_ovf_q   <= res_ovf_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.count_here    = out_count_q;
  assign out_o.running_total = out_total_q;
  assign out_o.overflow      = out_ovf_q;

`ifndef SYNTH
  a_done_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_sts.done |-> (tstate_q == T_RUN))
    else $error("walk finished outside of a running element");

  a_walker_idle_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tstate_q == T_IDLE) |-> !walk_sts.busy)
    else $error("walker busy while element slot is free");

  a_items_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    items_q <= ITEM_W'(MAX_ITEMS))
    else $error("element count beyond limit");
`endif

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the trie subarray xor below threshold counter
module testbench;
  import tsx_pkg::*;

  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned RANDOM_ITEMS  = 1150;
  localparam int unsigned SETTLE_CYCLES = 2 * VALUE_BITS_DEF + 4 + VALUE_BITS_DEF + 10;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam logic [THR_W-1:0] THR_ALL  = '1;
  localparam logic [THR_W-1:0] THR_MSB  = {1'b1, {(THR_W-1){1'b0}}};

  typedef struct packed {
    logic [COUNT_W-1:0] count_here;
    logic [TOTAL_W-1:0] running_total;
    logic               overflow;
  } tally_t;

  typedef struct {
    logic [THR_W-1:0]   thr;
    logic [VALUE_W-1:0] value;
    logic               first;
    bit                 typed;
    tally_t             want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  tsx_in_if  elem_ch ();
  tsx_out_if tally_ch ();

  trie_subarray_xor_below_count DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (elem_ch),
    .out_o       (tally_ch)
  );

  // array state as the block should hold it
  logic [VALUE_W-1:0] prefix_history[$];
  logic [VALUE_W-1:0] run_prefix;
  logic [TOTAL_W-1:0] array_total;
  int unsigned        elems_in_array;
  logic [THR_W-1:0]   thr_model;

  tally_t      pending_tallies[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned elements_sent;
  bit          calm;

  stim_row_t directed_rows [20] = '{
    '{32'h0,         32'h0000_0000, 1'b0, 1'b1, '{11'd0, 20'd0, 1'b0}},
    '{32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1, '{11'd0, 20'd0, 1'b0}},
    '{32'h0,         32'hA5A5_A5A5, 1'b1, 1'b1, '{11'd0, 20'd0, 1'b0}},
    '{32'h1,         32'h0000_0000, 1'b1, 1'b1, '{11'd1, 20'd1, 1'b0}},
    '{32'h1,         32'h0000_0000, 1'b0, 1'b1, '{11'd2, 20'd3, 1'b0}},
    '{32'h1,         32'h0000_0001, 1'b0, 1'b1, '{11'd0, 20'd3, 1'b0}},
    '{32'h1,         32'h0000_0001, 1'b0, 1'b1, '{11'd3, 20'd6, 1'b0}},
    '{THR_ALL,       32'hFFFF_FFFF, 1'b1, 1'b1, '{11'd0, 20'd0, 1'b0}},
    '{THR_ALL,       32'hFFFF_FFFF, 1'b0, 1'b1, '{11'd1, 20'd1, 1'b0}},
    '{THR_ALL,       32'h1234_5678, 1'b0, 1'b1, '{11'd3, 20'd4, 1'b0}},
    '{THR_MSB,       32'h8000_0000, 1'b1, 1'b1, '{11'd0, 20'd0, 1'b0}},
    '{THR_MSB,       32'h7FFF_FFFF, 1'b0, 1'b1, '{11'd1, 20'd1, 1'b0}},
    '{THR_MSB,       32'h8000_0000, 1'b0, 1'b1, '{11'd1, 20'd2, 1'b0}},
    '{32'h10,        32'h0000_0003, 1'b1, 1'b0, '0},
    '{32'h10,        32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h10,        32'h0000_000F, 1'b0, 1'b0, '0},
    '{32'h10,        32'h0000_0010, 1'b0, 1'b0, '0},
    '{32'h10,        32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'h10,        32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h10,        32'hFFFF_FFEF, 1'b0, 1'b0, '0}
  };

  function automatic void clear_array();
    prefix_history.delete();
    prefix_history.push_back('0);
    run_prefix     = '0;
    array_total    = '0;
    elems_in_array = 0;
  endfunction

  // count earlier prefixes whose xor with the new prefix is below the threshold
  function automatic tally_t tally_element(logic [VALUE_W-1:0] v, logic f);
    tally_t      t;
    int unsigned here;
    here = 0;
    if (f) clear_array();
    if (elems_in_array >= MAX_ITEMS_DEF) begin
      t.count_here    = '0;
      t.running_total = array_total;
      t.overflow      = 1'b1;
      return t;
    end
    elems_in_array++;
    run_prefix = run_prefix ^ v;
    foreach (prefix_history[i])
      if ((prefix_history[i] ^ run_prefix) < thr_model) here++;
    prefix_history.push_back(run_prefix);
    array_total     = array_total + TOTAL_W'(here);
    t.count_here    = COUNT_W'(here);
    t.running_total = array_total;
    t.overflow      = 1'b0;
    return t;
  endfunction

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    tally_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    tally_t want;
    if ((elem_ch.valid && elem_ch.ready) || (tally_ch.valid && tally_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("** trie_subarray_xor_below_count: FAILED **");
        $finish;
      end
    end
    if (rst_n && tally_ch.valid && tally_ch.ready) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got count_here %0d total %0d ovf %0b",
                 $time, tally_ch.count_here, tally_ch.running_total, tally_ch.overflow);
        fail_count++;
      end else begin
        want = pending_tallies.pop_front();
        if (tally_ch.count_here !== want.count_here) begin
          $display("%0t: count_here expected %0d, got %0d",
                   $time, want.count_here, tally_ch.count_here);
          fail_count++;
        end
        if (tally_ch.running_total !== want.running_total) begin
          $display("%0t: running_total expected %0d, got %0d",
                   $time, want.running_total, tally_ch.running_total);
          fail_count++;
        end
        if (tally_ch.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b, got %0b",
                   $time, want.overflow, tally_ch.overflow);
          fail_count++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic push_element(input logic [VALUE_W-1:0] v, input logic f,
                              input bit typed, input tally_t want);
    tally_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      elem_ch.valid <= 1'b0;
      @(negedge clk);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.value <= v;
    elem_ch.first <= f;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    predicted = tally_element(v, f);
    pending_tallies.push_back(typed ? want : predicted);
    elements_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    elem_ch.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] thr);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    thr_model = thr;
  endtask

  task automatic short_array();
    int unsigned        len;
    logic [VALUE_W-1:0] mask;
    logic               f;
    len = $urandom_range(1, 14);
    case ($urandom_range(0, 3))
      0: mask = '1;
      1: mask = 32'hFF;
      2: mask = 32'hF;
      default: mask = 32'h3;
    endcase
    for (int i = 0; i < len; i++) begin
      f = (i == 0) ? ($urandom_range(99) < 88) : ($urandom_range(99) < 3);
      push_element($urandom & mask, f, 1'b0, '0);
    end
  endtask

  // runs past MAX_ITEMS so the last elements overflow; the msb stays clear so
  // every earlier prefix counts under the all-ones threshold
  task automatic long_array();
    for (int i = 0; i < MAX_ITEMS_DEF + 6; i++) begin
      calm = (i >= 100 && i < 450);
      push_element($urandom & 32'h7FFF_FFFF, i == 0, 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned directed_count;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    elem_ch.valid  = 1'b0;
    elem_ch.value  = '0;
    elem_ch.first  = 1'b0;
    tally_ch.ready = 1'b0;
    calm           = 1'b0;
    fail_count     = 0;
    quiet_cycles   = 0;
    elements_sent  = 0;
    thr_model      = '0;
    clear_array();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].thr != thr_model) set_threshold(directed_rows[i].thr);
      push_element(directed_rows[i].value, directed_rows[i].first,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    directed_count = elements_sent;

    phase = 0;
    while (elements_sent - directed_count < RANDOM_ITEMS) begin
      case (phase % 6)
        0: set_threshold($urandom_range(0, 300));
        1: set_threshold($urandom);
        2: set_threshold(THR_ALL);
        3: set_threshold('0);
        4: set_threshold(THR_MSB);
        default: set_threshold($urandom >> $urandom_range(0, 31));
      endcase
      if (phase == 2) begin
        long_array();
      end
      repeat ($urandom_range(2, 5)) short_array();
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("** trie_subarray_xor_below_count: PASSED **");
    end else begin
      $display("** trie_subarray_xor_below_count: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tsx_pkg.sv
design/tsx_if.sv
design/tsx_node_mem.sv
design/tsx_walker.sv
design/trie_subarray_xor_below_count.sv
verif/testbench.sv
